### src/assert_macros.svh
// Assertion macros shared by the modules of the pick amplitude gate.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define CHK_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/dpag_pkg.sv
// Package of the deferred pick amplitude gate: payload types, codes,
// the configuration struct and the threshold decay table. No dependencies.
`default_nettype none

package dpag_pkg;

    localparam int DECAY_TABLE_DEPTH = 256;
    localparam int DEPTH_W = $clog2(DECAY_TABLE_DEPTH);
    localparam int ENTRY_W = 13;
    localparam int DEN_W   = 18;
    localparam int NUM_W   = DEN_W + DEPTH_W + 1;

    localparam logic [2:0] OPC_SAMPLE   = 3'd0;
    localparam logic [2:0] OPC_TRIG_ON  = 3'd1;
    localparam logic [2:0] OPC_PICK     = 3'd2;
    localparam logic [2:0] OPC_TRIG_OFF = 3'd3;
    localparam logic [2:0] OPC_GAP      = 3'd4;

    localparam logic [1:0] CFG_AMP_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_DEAD_TIME     = 2'd1;
    localparam logic [1:0] CFG_WINDOW        = 2'd2;
    localparam logic [1:0] CFG_PUBLISH       = 2'd3;

    localparam logic RESULT_PICK = 1'b0;
    localparam logic RESULT_AMP  = 1'b1;

    typedef enum logic [2:0] {
        KIND_SAMPLE,
        KIND_TRIG_ON,
        KIND_PICK,
        KIND_TRIG_OFF,
        KIND_GAP,
        KIND_NONE
    } op_kind_t;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_RANGE,
        EX_DIVIDE,
        EX_SCALE,
        EX_SUM,
        EX_DECIDE
    } exec_state_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [23:0] sample_value;
        logic [31:0]        event_time;
        logic [15:0]        gap_samples;
        logic               gap_ok;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] pick_time;
        logic [23:0] amplitude;
        logic [15:0] max_offset;
        logic        last;
    } out_item_t;

    typedef struct packed {
        op_kind_t kind;
        in_item_t item;
    } cmd_t;

    typedef struct packed {
        logic [23:0] amp_threshold;
        logic [15:0] dead_time_samples;
        logic [15:0] window_samples;
        logic        publish_enable;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef logic [ENTRY_W-1:0] decay_table_t [DECAY_TABLE_DEPTH];

    // Shift and subtract long division, used only while the table is built.
    function automatic longint unsigned div_u64(longint unsigned n, longint unsigned dv);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            q = q << 1;
            if (r >= dv)
            begin
                r = r - dv;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // One table entry: exp(-(k/D)^2 * 16) evaluated as exp(-g)^16 with g in Q30,
    // a Taylor series up to the 20th power and four squarings, rounded to Q12.
    function automatic logic [ENTRY_W-1:0] decay_entry(int unsigned k);
        longint unsigned d;
        longint unsigned g;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned v;
        longint unsigned kk;
        d    = longint'(DECAY_TABLE_DEPTH);
        kk   = longint'(k);
        g    = div_u64((kk * kk) << 30, d * d);
        term = 64'd1 << 30;
        pos  = 64'd1 << 30;
        neg  = 64'd0;
        for (int i = 1; i <= 20; i++)
        begin
            term = div_u64((term * g) >> 30, longint'(i));
            if ((i & 1) == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        v = pos - neg;
        for (int j = 0; j < 4; j++)
            v = (v * v + (64'd1 << 29)) >> 30;
        return ENTRY_W'((v + (64'd1 << 17)) >> 18);
    endfunction

    function automatic decay_table_t build_decay_table();
        decay_table_t t;
        for (int k = 0; k < DECAY_TABLE_DEPTH; k++)
            t[k] = decay_entry(k);
        return t;
    endfunction

    localparam decay_table_t DECAY_TABLE = build_decay_table();

endpackage

`default_nettype wire

### src/dpag_divider.sv
// Restoring divider for the decay table index, one quotient bit per cycle.
// Depends on dpag_pkg for widths and the status struct.
`default_nettype none

module dpag_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [dpag_pkg::NUM_W-1:0]   num,
    input  wire logic [dpag_pkg::DEN_W-1:0]   den,
    output dpag_pkg::div_status_t             status,
    output logic [dpag_pkg::DEPTH_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(dpag_pkg::DEPTH_W + 1);

    logic [dpag_pkg::NUM_W-1:0]   rem_reg, rem_next;
    logic [dpag_pkg::NUM_W-1:0]   dsh_reg, dsh_next;
    logic [dpag_pkg::DEPTH_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic                         fits;

    // The caller guarantees num < den * 2^DEPTH_W, so DEPTH_W steps suffice.
    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = dpag_pkg::NUM_W'(den) << (dpag_pkg::DEPTH_W - 1);
            quo_next  = '0;
            step_next = STEP_W'(dpag_pkg::DEPTH_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = rem_reg - dsh_reg;
            quo_next  = {quo_reg[dpag_pkg::DEPTH_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

### src/dpag_front.sv
// Front end: accepts requests, decodes the opcode and queues up to two commands.
// Depends on dpag_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dpag_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire dpag_pkg::in_item_t  item,
    output logic                     cmd_valid,
    output dpag_pkg::cmd_t           cmd,
    input  wire logic                cmd_pop
);

    dpag_pkg::cmd_t    q_reg [2];
    dpag_pkg::cmd_t    q_next [2];
    logic [1:0]        cnt_reg, cnt_next;
    dpag_pkg::cmd_t    incoming;
    logic              push;
    logic              pop;

    always_comb
    begin
        incoming.item = item;
        unique case (item.opcode)
            dpag_pkg::OPC_SAMPLE:   incoming.kind = dpag_pkg::KIND_SAMPLE;
            dpag_pkg::OPC_TRIG_ON:  incoming.kind = dpag_pkg::KIND_TRIG_ON;
            dpag_pkg::OPC_PICK:     incoming.kind = dpag_pkg::KIND_PICK;
            dpag_pkg::OPC_TRIG_OFF: incoming.kind = dpag_pkg::KIND_TRIG_OFF;
            dpag_pkg::OPC_GAP:      incoming.kind = dpag_pkg::KIND_GAP;
            default:                incoming.kind = dpag_pkg::KIND_NONE;
        endcase
    end

    assign item_stall = (cnt_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign pop        = cmd_pop && (cnt_reg != 2'd0);
    assign cmd_valid  = (cnt_reg != 2'd0);
    assign cmd        = q_reg[0];

    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        if (pop)
            q_next[0] = q_reg[1];
        if (push)
        begin
            if ((cnt_reg - 2'(pop)) == 2'd0)
                q_next[0] = incoming;
            else
                q_next[1] = incoming;
        end
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

    `CHK_IMPLIES(a_pop_has_entry, cmd_pop, cnt_reg != 2'd0)
    `CHK_NEXT(a_push_grows, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1)
    `CHK_NEXT(a_pop_shrinks, pop && !push, cnt_reg == $past(cnt_reg) - 2'd1)

endmodule

`default_nettype wire

### src/dpag_exec.sv
// Back end: window tracking, repick threshold and pick release, with a
// two-entry result buffer. Depends on dpag_pkg, dpag_divider, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dpag_exec (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dpag_pkg::cfg_t      cfg,
    input  wire logic                cmd_valid,
    input  wire dpag_pkg::cmd_t      cmd,
    output logic                     cmd_pop,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output dpag_pkg::out_item_t      result
);

    dpag_pkg::exec_state_t state_reg, state_next;

    logic [31:0] last_pick_time_reg, last_pick_time_next;
    logic        last_pick_valid_reg, last_pick_valid_next;
    logic [23:0] last_amp_reg, last_amp_next;
    logic        last_amp_valid_reg, last_amp_valid_next;
    logic [24:0] min_amp_reg, min_amp_next;
    logic        min_amp_valid_reg, min_amp_valid_next;
    logic [23:0] trig_amp_reg, trig_amp_next;
    logic [31:0] held_time_reg, held_time_next;
    logic        held_valid_reg, held_valid_next;
    logic [23:0] wmax_reg, wmax_next;
    logic        wmax_valid_reg, wmax_valid_next;
    logic [15:0] widx_reg, widx_next;
    logic [15:0] wcount_reg, wcount_next;
    logic [15:0] wneeded_reg, wneeded_next;
    logic        pick_sent_reg, pick_sent_next;

    logic [31:0]                   pick_t_reg, pick_t_next;
    logic [31:0]                   adt_reg, adt_next;
    logic [dpag_pkg::ENTRY_W-1:0]  entry_reg, entry_next;
    logic [36:0]                   prod_reg, prod_next;
    logic [24:0]                   th_reg, th_next;

    dpag_pkg::out_item_t ob_reg [2];
    dpag_pkg::out_item_t ob_next [2];
    logic [1:0]          ob_cnt_reg, ob_cnt_next;

    dpag_pkg::out_item_t r0, r1;
    logic [1:0]          nres;
    logic                do_feed, do_finish, do_send, clear_sent, win_ok, ob_pop;
    logic [31:0]         send_t, diff;
    logic [23:0]         a_abs, fin_amp;
    logic [15:0]         fin_off;
    logic                fin_valid;
    logic [16:0]         gap_sum;
    logic [36:0]         rounded;
    logic [25:0]         th_sum;

    logic                         div_start;
    logic [dpag_pkg::NUM_W-1:0]   div_num;
    dpag_pkg::div_status_t        div_status;
    logic [dpag_pkg::DEPTH_W-1:0] quotient;

    dpag_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      ({cfg.dead_time_samples, 2'b00}),
        .status   (div_status),
        .quotient (quotient)
    );

    // Only the low bits matter once the range check has passed.
    assign div_num = dpag_pkg::NUM_W'(adt_reg[dpag_pkg::DEN_W-1:0])
                     * dpag_pkg::NUM_W'(dpag_pkg::DECAY_TABLE_DEPTH);

    function automatic dpag_pkg::out_item_t mk(logic kind, logic [31:0] t,
                                               logic [23:0] a, logic [15:0] off);
        dpag_pkg::out_item_t r;
        r.result_kind = kind;
        r.pick_time   = t;
        r.amplitude   = a;
        r.max_offset  = off;
        r.last        = 1'b0;
        return r;
    endfunction

    assign cmd_pop = cmd_valid && (state_reg == dpag_pkg::EX_IDLE) && (ob_cnt_reg == 2'd0);
    assign a_abs   = cmd.item.sample_value[23] ? (24'd0 - cmd.item.sample_value)
                                               : cmd.item.sample_value;
    assign diff    = cmd.item.event_time - last_pick_time_reg;
    assign gap_sum = {1'b0, wcount_reg} + {1'b0, cmd.item.gap_samples};
    assign rounded = prod_reg + 37'd2048;
    assign th_sum  = {2'b00, cfg.amp_threshold} + {1'b0, rounded[36:12]};

    always_comb
    begin
        state_next           = state_reg;
        last_pick_time_next  = last_pick_time_reg;
        last_pick_valid_next = last_pick_valid_reg;
        last_amp_next        = last_amp_reg;
        last_amp_valid_next  = last_amp_valid_reg;
        min_amp_next         = min_amp_reg;
        min_amp_valid_next   = min_amp_valid_reg;
        trig_amp_next        = trig_amp_reg;
        held_time_next       = held_time_reg;
        held_valid_next      = held_valid_reg;
        wmax_next            = wmax_reg;
        wmax_valid_next      = wmax_valid_reg;
        widx_next            = widx_reg;
        wcount_next          = wcount_reg;
        wneeded_next         = wneeded_reg;
        pick_sent_next       = pick_sent_reg;
        pick_t_next          = pick_t_reg;
        adt_next             = adt_reg;
        entry_next           = entry_reg;
        prod_next            = prod_reg;
        th_next              = th_reg;
        r0                   = '0;
        r1                   = '0;
        nres                 = 2'd0;
        do_feed              = 1'b0;
        do_finish            = 1'b0;
        do_send              = 1'b0;
        clear_sent           = 1'b0;
        send_t               = '0;
        div_start            = 1'b0;
        fin_amp              = '0;
        fin_off              = '0;
        fin_valid            = 1'b0;
        win_ok               = 1'b0;

        unique case (state_reg)
            dpag_pkg::EX_IDLE:
            begin
                if (cmd_pop)
                begin
                    unique case (cmd.kind)
                        dpag_pkg::KIND_SAMPLE:
                            do_feed = 1'b1;
                        dpag_pkg::KIND_TRIG_ON:
                        begin
                            wmax_next          = '0;
                            wmax_valid_next    = 1'b0;
                            widx_next          = '0;
                            wcount_next        = '0;
                            wneeded_next       = cfg.window_samples;
                            trig_amp_next      = cmd.item.sample_value;
                            min_amp_valid_next = 1'b0;
                            pick_sent_next     = 1'b0;
                            do_feed            = 1'b1;
                        end
                        dpag_pkg::KIND_PICK:
                        begin
                            pick_t_next = cmd.item.event_time;
                            if (last_amp_valid_reg && last_pick_valid_reg)
                            begin
                                if (cfg.dead_time_samples == 16'd0)
                                begin
                                    th_next    = {1'b0, cfg.amp_threshold};
                                    state_next = dpag_pkg::EX_DECIDE;
                                end
                                else
                                begin
                                    adt_next   = diff[31] ? (32'd0 - diff) : diff;
                                    state_next = dpag_pkg::EX_RANGE;
                                end
                            end
                            else
                            begin
                                do_send = 1'b1;
                                send_t  = cmd.item.event_time;
                            end
                        end
                        dpag_pkg::KIND_TRIG_OFF:
                        begin
                            if (wneeded_reg != 16'd0)
                                do_finish = 1'b1;
                            clear_sent = 1'b1;
                        end
                        dpag_pkg::KIND_GAP:
                        begin
                            if (cmd.item.gap_ok)
                            begin
                                if (wneeded_reg != 16'd0)
                                    wcount_next = gap_sum[16] ? 16'hFFFF : gap_sum[15:0];
                            end
                            else
                            begin
                                last_pick_time_next  = '0;
                                last_pick_valid_next = 1'b0;
                                last_amp_next        = '0;
                                last_amp_valid_next  = 1'b0;
                                held_time_next       = '0;
                                held_valid_next      = 1'b0;
                                min_amp_next         = '0;
                                min_amp_valid_next   = 1'b0;
                                trig_amp_next        = '0;
                                wmax_next            = '0;
                                wmax_valid_next      = 1'b0;
                                widx_next            = '0;
                                wcount_next          = '0;
                                wneeded_next         = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dpag_pkg::EX_RANGE:
            begin
                if (adt_reg >= {14'd0, cfg.dead_time_samples, 2'b00})
                begin
                    th_next    = {1'b0, cfg.amp_threshold};
                    state_next = dpag_pkg::EX_DECIDE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = dpag_pkg::EX_DIVIDE;
                end
            end
            dpag_pkg::EX_DIVIDE:
            begin
                if (div_status.done)
                begin
                    entry_next = dpag_pkg::DECAY_TABLE[quotient];
                    state_next = dpag_pkg::EX_SCALE;
                end
            end
            dpag_pkg::EX_SCALE:
            begin
                prod_next  = 37'(last_amp_reg) * 37'(entry_reg);
                state_next = dpag_pkg::EX_SUM;
            end
            dpag_pkg::EX_SUM:
            begin
                th_next    = th_sum[25] ? 25'h1FFFFFF : th_sum[24:0];
                state_next = dpag_pkg::EX_DECIDE;
            end
            dpag_pkg::EX_DECIDE:
            begin
                min_amp_next       = th_reg;
                min_amp_valid_next = 1'b1;
                if ($signed({1'b0, th_reg}) > $signed({{2{trig_amp_reg[23]}}, trig_amp_reg}))
                begin
                    held_time_next  = pick_t_reg;
                    held_valid_next = 1'b1;
                end
                else
                begin
                    do_send = 1'b1;
                    send_t  = pick_t_reg;
                end
                state_next = dpag_pkg::EX_IDLE;
            end
            default:
                state_next = dpag_pkg::EX_IDLE;
        endcase

        // Window feeding works on the state after a trigger-on reset.
        if (do_feed && (wneeded_next != 16'd0))
        begin
            if (wcount_next < wneeded_next)
            begin
                if (!wmax_valid_next || (a_abs > wmax_next))
                begin
                    wmax_next       = a_abs;
                    widx_next       = wcount_next;
                    wmax_valid_next = 1'b1;
                end
                wcount_next = wcount_next + 16'd1;
            end
            if (wcount_next >= wneeded_next)
                do_finish = 1'b1;
        end

        if (do_finish)
        begin
            fin_amp             = wmax_next;
            fin_off             = widx_next;
            fin_valid           = wmax_valid_next;
            last_amp_next       = fin_amp;
            last_amp_valid_next = fin_valid;
            wmax_next           = '0;
            wmax_valid_next     = 1'b0;
            widx_next           = '0;
            wcount_next         = '0;
            wneeded_next        = '0;
            win_ok = fin_valid && !(min_amp_valid_next && ({1'b0, fin_amp} < min_amp_next));
            if (win_ok)
            begin
                if (held_valid_next)
                begin
                    r0                   = mk(dpag_pkg::RESULT_PICK, held_time_next, '0, '0);
                    nres                 = 2'd1;
                    last_pick_time_next  = held_time_next;
                    last_pick_valid_next = 1'b1;
                    min_amp_valid_next   = 1'b0;
                    held_valid_next      = 1'b0;
                    held_time_next       = '0;
                    pick_sent_next       = 1'b1;
                end
                if (cfg.publish_enable && pick_sent_next)
                begin
                    if (nres == 2'd0)
                        r0 = mk(dpag_pkg::RESULT_AMP, last_pick_time_next, fin_amp, fin_off);
                    else
                        r1 = mk(dpag_pkg::RESULT_AMP, last_pick_time_next, fin_amp, fin_off);
                    nres = nres + 2'd1;
                end
            end
        end

        if (do_send)
        begin
            r0                   = mk(dpag_pkg::RESULT_PICK, send_t, '0, '0);
            nres                 = 2'd1;
            last_pick_time_next  = send_t;
            last_pick_valid_next = 1'b1;
            min_amp_valid_next   = 1'b0;
            held_valid_next      = 1'b0;
            held_time_next       = '0;
            pick_sent_next       = 1'b1;
        end

        if (clear_sent)
            pick_sent_next = 1'b0;

        if (nres == 2'd1)
            r0.last = 1'b1;
        else if (nres == 2'd2)
            r1.last = 1'b1;
    end

    // Result buffer: loaded only while empty, drained from the head.
    assign ob_pop       = (ob_cnt_reg != 2'd0) && !result_stall;
    assign result_valid = (ob_cnt_reg != 2'd0);
    assign result       = ob_reg[0];

    always_comb
    begin
        ob_next[0]  = ob_reg[0];
        ob_next[1]  = ob_reg[1];
        ob_cnt_next = ob_cnt_reg;
        if (nres != 2'd0)
        begin
            ob_next[0]  = r0;
            ob_next[1]  = r1;
            ob_cnt_next = nres;
        end
        else if (ob_pop)
        begin
            ob_next[0]  = ob_reg[1];
            ob_cnt_next = ob_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= dpag_pkg::EX_IDLE;
            last_pick_time_reg  <= '0;
            last_pick_valid_reg <= 1'b0;
            last_amp_reg        <= '0;
            last_amp_valid_reg  <= 1'b0;
            min_amp_reg         <= '0;
            min_amp_valid_reg   <= 1'b0;
            trig_amp_reg        <= '0;
            held_time_reg       <= '0;
            held_valid_reg      <= 1'b0;
            wmax_reg            <= '0;
            wmax_valid_reg      <= 1'b0;
            widx_reg            <= '0;
            wcount_reg          <= '0;
            wneeded_reg         <= '0;
            pick_sent_reg       <= 1'b0;
            ob_cnt_reg          <= 2'd0;
        end
        else
        begin
            state_reg           <= state_next;
            last_pick_time_reg  <= last_pick_time_next;
            last_pick_valid_reg <= last_pick_valid_next;
            last_amp_reg        <= last_amp_next;
            last_amp_valid_reg  <= last_amp_valid_next;
            min_amp_reg         <= min_amp_next;
            min_amp_valid_reg   <= min_amp_valid_next;
            trig_amp_reg        <= trig_amp_next;
            held_time_reg       <= held_time_next;
            held_valid_reg      <= held_valid_next;
            wmax_reg            <= wmax_next;
            wmax_valid_reg      <= wmax_valid_next;
            widx_reg            <= widx_next;
            wcount_reg          <= wcount_next;
            wneeded_reg         <= wneeded_next;
            pick_sent_reg       <= pick_sent_next;
            ob_cnt_reg          <= ob_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_t_reg <= pick_t_next;
        adt_reg    <= adt_next;
        entry_reg  <= entry_next;
        prod_reg   <= prod_next;
        th_reg     <= th_next;
        ob_reg[0]  <= ob_next[0];
        ob_reg[1]  <= ob_next[1];
    end

    `CHK_IMPLIES(a_load_when_empty, nres != 2'd0, ob_cnt_reg == 2'd0)
    `CHK_IMPLIES(a_div_done_waited, div_status.done, state_reg == dpag_pkg::EX_DIVIDE)
    `CHK_NEXT(a_decide_returns, state_reg == dpag_pkg::EX_DECIDE, state_reg == dpag_pkg::EX_IDLE)

endmodule

`default_nettype wire

### src/deferred_pick_amplitude_gate_core.sv
// Top level of the deferred pick amplitude gate: configuration registers,
// front queue and execution unit. Depends on dpag_pkg, dpag_front, dpag_exec.
`default_nettype none

// The gate takes trigger events (sample, trigger-on, pick request, trigger-off,
// gap) as requests on the item channel and returns pick and window amplitude
// results on the result channel, at most two per request, the final one
// flagged by last. A two-entry front queue keeps taking requests, until it
// holds two, while the execution unit works or while results wait to be
// taken. Samples, trigger edges and gaps are handled in the idle state. A
// pick request that needs a repick threshold passes through a range check,
// the restoring divider that forms the decay table index one bit per cycle,
// the table lookup, a 24 by 13 bit multiply, a saturating add and the
// decision. The execution unit starts the next request only after all
// results of the previous one have been taken. Configuration is written
// through cfg_we, cfg_index and cfg_data and must only change while the
// gate is idle.
module deferred_pick_amplitude_gate_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire dpag_pkg::in_item_t   item,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output dpag_pkg::out_item_t       result,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [23:0]          cfg_data
);

    dpag_pkg::cfg_t cfg_reg;
    dpag_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    // Registers take their documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amp_threshold     <= 24'd12288;
            cfg_reg.dead_time_samples <= 16'd1000;
            cfg_reg.window_samples    <= 16'd1000;
            cfg_reg.publish_enable    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dpag_pkg::CFG_AMP_THRESHOLD: cfg_reg.amp_threshold     <= cfg_data;
                dpag_pkg::CFG_DEAD_TIME:     cfg_reg.dead_time_samples <= cfg_data[15:0];
                dpag_pkg::CFG_WINDOW:        cfg_reg.window_samples    <= cfg_data[15:0];
                dpag_pkg::CFG_PUBLISH:       cfg_reg.publish_enable    <= cfg_data[0];
            endcase
        end
    end

    // The front decodes and queues requests independently of the back end.
    dpag_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    // The back end holds all picking and window state and the result buffer.
    dpag_exec u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
